// ===== rtl/udpf_pkg.sv =====
// Shared types and constants for the UDP frame receive filter.
`timescale 1ns / 1ps
package udpf_pkg;

  localparam logic [16:0] POS_MAX          = 17'h1FFFF;
  localparam logic [16:0] POS_ETYPE_HI     = 17'd12;
  localparam logic [16:0] POS_ETYPE_LO     = 17'd13;
  localparam logic [16:0] POS_VER_IHL      = 17'd14;
  localparam logic [16:0] POS_PROTOCOL     = 17'd23;
  localparam logic [16:0] POS_SRC_FIRST    = 17'd26;
  localparam logic [16:0] POS_SRC_LAST     = 17'd29;

  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [3:0]  IPV4_VERSION     = 4'd4;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [5:0]  MIN_IHL_BYTES    = 6'd20;
  localparam logic [6:0]  ETH_HDR          = 7'd14;
  localparam logic [15:0] UDP_HDR          = 16'd8;
  localparam logic [17:0] MIN_FRAME_LEN    = 18'd42;
  localparam logic [15:0] UDP_PORT_RESET   = 16'd12345;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    REASON_OK         = 3'd0,
    REASON_SHORT      = 3'd1,
    REASON_ETHERTYPE  = 3'd2,
    REASON_VERSION    = 3'd3,
    REASON_IHL        = 3'd4,
    REASON_PROTOCOL   = 3'd5,
    REASON_PORT       = 3'd6,
    REASON_UDP_LENGTH = 3'd7
  } reason_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic        accepted;
    reason_t     reject_reason;
    logic [31:0] source_ip;
    logic [15:0] payload_length;
    logic        last;
  } result_t;

  // Up to two results per item; first is always the one delivered first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== rtl/udpf_byte_if.sv =====
// Input channel: one frame byte per item with a last-byte flag.
`timescale 1ns / 1ps
interface udpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ===== rtl/udpf_result_if.sv =====
// Output channel: payload bytes and end-of-frame verdicts.
`timescale 1ns / 1ps
interface udpf_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic        accepted;
  logic [2:0]  reject_reason;
  logic [31:0] source_ip;
  logic [15:0] payload_length;
  logic        last;

  modport source (output valid, result_kind, payload_byte, accepted, reject_reason,
                  source_ip, payload_length, last, input ready);
  modport sink   (input valid, result_kind, payload_byte, accepted, reject_reason,
                  source_ip, payload_length, last, output ready);
endinterface

// ===== rtl/udpf_parser.sv =====
// Input register, header capture, payload gating and verdict generation.
`timescale 1ns / 1ps
module udpf_parser
  import udpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  udpf_byte_if.sink    rx,
  input  logic         udp_port_we,
  input  logic [15:0]  udp_port_wdata,
  input  logic         space_ok,
  output push_t        push
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        fire;

  logic [15:0] udp_port;
  logic [16:0] frame_position;
  logic [15:0] ether_type;
  logic [7:0]  version_and_ihl;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [15:0] dest_port_seen;
  logic [15:0] udp_length_seen;

  logic [5:0]  ihl_bytes;
  logic [16:0] udp_start;
  logic [16:0] pay_lo;
  logic [17:0] pay_hi;
  logic [17:0] frame_len;
  logic [17:0] udp_end;
  logic        header_ok;
  logic        emit_payload;
  reason_t     reason;
  result_t     pay_res;
  result_t     ver_res;

  assign fire     = in_valid && space_ok;
  assign rx.ready = !in_valid || space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.data_byte;
      in_last <= rx.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_port <= UDP_PORT_RESET;
    end else if (udp_port_we) begin
      udp_port <= udp_port_wdata;
    end
  end

  assign ihl_bytes = {version_and_ihl[3:0], 2'b00};
  assign udp_start = {10'd0, ETH_HDR} + {11'd0, ihl_bytes};
  assign pay_lo    = udp_start + {1'b0, UDP_HDR};
  assign pay_hi    = {1'b0, udp_start} + {2'b00, udp_length_seen};
  assign frame_len = {1'b0, frame_position} + 18'd1;
  assign udp_end   = {1'b0, udp_start} + {2'b00, udp_length_seen};

  // Every header field is captured before the earliest payload position.
  assign header_ok = (ether_type == ETHERTYPE_IPV4) &&
                     (version_and_ihl[7:4] == IPV4_VERSION) &&
                     (ihl_bytes >= MIN_IHL_BYTES) &&
                     (protocol_number == PROTO_UDP) &&
                     (dest_port_seen == udp_port) &&
                     (udp_length_seen >= UDP_HDR);

  assign emit_payload = header_ok && (frame_position >= pay_lo) &&
                        ({1'b0, frame_position} < pay_hi);

  always_comb begin
    if (frame_len < MIN_FRAME_LEN) begin
      reason = REASON_SHORT;
    end else if (ether_type != ETHERTYPE_IPV4) begin
      reason = REASON_ETHERTYPE;
    end else if (version_and_ihl[7:4] != IPV4_VERSION) begin
      reason = REASON_VERSION;
    end else if (ihl_bytes < MIN_IHL_BYTES) begin
      reason = REASON_IHL;
    end else if (frame_len < {1'b0, pay_lo}) begin
      reason = REASON_SHORT;
    end else if (protocol_number != PROTO_UDP) begin
      reason = REASON_PROTOCOL;
    end else if (dest_port_seen != udp_port) begin
      reason = REASON_PORT;
    end else if ((udp_length_seen < UDP_HDR) || (udp_end > frame_len)) begin
      reason = REASON_UDP_LENGTH;
    end else begin
      reason = REASON_OK;
    end
  end

  always_comb begin
    pay_res                = '0;
    pay_res.result_kind    = KIND_PAYLOAD;
    pay_res.payload_byte   = in_byte;
    pay_res.reject_reason  = REASON_OK;

    ver_res                = '0;
    ver_res.result_kind    = KIND_VERDICT;
    ver_res.last           = 1'b1;
    ver_res.reject_reason  = reason;
    if (reason == REASON_OK) begin
      ver_res.accepted       = 1'b1;
      ver_res.source_ip      = source_address;
      ver_res.payload_length = udp_length_seen - UDP_HDR;
    end
  end

  always_comb begin
    push        = '0;
    push.second = ver_res;
    if (fire) begin
      push.count = {1'b0, emit_payload} + {1'b0, in_last};
    end
    push.first = emit_payload ? pay_res : ver_res;
  end

  // Frame state: capture header bytes, clear after the verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position  <= '0;
      ether_type      <= '0;
      version_and_ihl <= '0;
      protocol_number <= '0;
      source_address  <= '0;
      dest_port_seen  <= '0;
      udp_length_seen <= '0;
    end else if (fire) begin
      if (in_last) begin
        frame_position  <= '0;
        ether_type      <= '0;
        version_and_ihl <= '0;
        protocol_number <= '0;
        source_address  <= '0;
        dest_port_seen  <= '0;
        udp_length_seen <= '0;
      end else begin
        if (frame_position != POS_MAX) begin
          frame_position <= frame_position + 17'd1;
        end
        if (frame_position == POS_ETYPE_HI) begin
          ether_type[15:8] <= in_byte;
        end
        if (frame_position == POS_ETYPE_LO) begin
          ether_type[7:0] <= in_byte;
        end
        if (frame_position == POS_VER_IHL) begin
          version_and_ihl <= in_byte;
        end
        if (frame_position == POS_PROTOCOL) begin
          protocol_number <= in_byte;
        end
        if ((frame_position >= POS_SRC_FIRST) && (frame_position <= POS_SRC_LAST)) begin
          source_address <= {source_address[23:0], in_byte};
        end
        if (frame_position > POS_VER_IHL) begin
          if (frame_position == udp_start + 17'd2) begin
            dest_port_seen[15:8] <= in_byte;
          end
          if (frame_position == udp_start + 17'd3) begin
            dest_port_seen[7:0] <= in_byte;
          end
          if (frame_position == udp_start + 17'd4) begin
            udp_length_seen[15:8] <= in_byte;
          end
          if (frame_position == udp_start + 17'd5) begin
            udp_length_seen[7:0] <= in_byte;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/udpf_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, delivers one.
`timescale 1ns / 1ps
module udpf_result_fifo
  import udpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  push_t    push,
  output logic     space_ok,
  output logic     head_valid,
  output result_t  head,
  input  logic     pop
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign space_ok   = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(do_pop);
    end
  end

endmodule

// ===== rtl/udp_frame_receive_filter.sv =====
// Top level of the UDP frame receive filter.
`timescale 1ns / 1ps
// Takes an Ethernet II frame one byte per item on rx (last_byte marks the end)
// and checks it as IPv4/UDP addressed to the udp_port register (reset 12345,
// written with udp_port_we/udp_port_wdata; the user must write it only while
// idle, which the block does not enforce). Bytes inside the UDP payload range
// are forwarded at once on tx as tentative payload items (result_kind 0)
// while the header checks pass so far; the verdict item (result_kind 1,
// last 1) on the final byte may still reject the frame for a short frame or
// a bad UDP length. A final byte inside the payload gives the payload item
// first, then the verdict. Rate: one byte per clock while the result queue
// has room; each byte is held in the input register until the queue has
// room, is decoded against the captured header fields, and its results enter
// a four-entry result queue that drains one item per clock while tx is ready,
// so a byte that yields both a payload item and a verdict gives the output
// side two items to drain. A frame position counter saturates at 131071.
module udp_frame_receive_filter
  import udpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  udpf_byte_if.sink     rx,
  udpf_result_if.source tx,
  input  logic          udp_port_we,
  input  logic [15:0]   udp_port_wdata
);

  push_t   push;
  logic    space_ok;
  logic    head_valid;
  result_t head;

  // Register the byte, update header state, build up to two results.
  udpf_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx),
    .udp_port_we    (udp_port_we),
    .udp_port_wdata (udp_port_wdata),
    .space_ok       (space_ok),
    .push           (push)
  );

  // Hold results until the sink takes them; stall the parser when near full.
  udpf_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head       (head),
    .pop        (tx.ready)
  );

  // Drive the result channel from the queue head.
  assign tx.valid          = head_valid;
  assign tx.result_kind    = head.result_kind;
  assign tx.payload_byte   = head.payload_byte;
  assign tx.accepted       = head.accepted;
  assign tx.reject_reason  = 3'(head.reject_reason);
  assign tx.source_ip      = head.source_ip;
  assign tx.payload_length = head.payload_length;
  assign tx.last           = head.last;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the UDP frame receive filter: frames in, payload items and verdicts out.
`timescale 1ns / 1ps
module tb_top;
  import udpf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic [7:0] data_byte;
    logic       last_byte;
    bit         typed;
    result_t    want;
  } stim_row_t;

  localparam result_t SHORT_VERDICT = '{result_kind: KIND_VERDICT, payload_byte: 8'h00,
                                        accepted: 1'b0, reject_reason: REASON_SHORT,
                                        source_ip: 32'h0, payload_length: 16'h0, last: 1'b1};
  localparam result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        udp_port_we;
  logic [15:0] udp_port_wdata;

  udpf_byte_if   rx_if ();
  udpf_result_if tx_if ();

  udp_frame_receive_filter dut (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx_if),
    .tx             (tx_if),
    .udp_port_we    (udp_port_we),
    .udp_port_wdata (udp_port_wdata)
  );

  always #1 clk = ~clk;

  // Directed frames: two one-byte frames at the byte extremes, then a frame cut off inside
  // the IPv4 header. All three end short, so their verdicts are typed in.
  stim_row_t dir_rows [24] = '{
    '{8'h00, 1'b1, 1'b1, SHORT_VERDICT},
    '{8'hFF, 1'b1, 1'b1, SHORT_VERDICT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h02, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h01, 1'b0, 1'b0, NO_RESULT},
    '{8'h08, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h45, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h1C, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h40, 1'b0, 1'b0, NO_RESULT}, '{8'h11, 1'b1, 1'b1, SHORT_VERDICT}
  };

  // Filter state mirrored by the predictor
  logic [15:0] cfg_port = UDP_PORT_RESET;
  logic [16:0] pos      = '0;
  logic [15:0] etype    = '0;
  logic [7:0]  ver_ihl  = '0;
  logic [7:0]  proto    = '0;
  logic [31:0] src_addr = '0;
  logic [15:0] dport    = '0;
  logic [15:0] ulen     = '0;

  result_t    awaited_items[$];
  logic [7:0] frame_q[$];

  int err_count     = 0;
  int cycle_count   = 0;
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int stall_request = 0;
  int hold_left     = 0;
  result_t seen_item;
  result_t want_item;

  // Advance the mirrored frame state by one byte and queue the items it causes.
  function automatic void filter_one_byte(input logic [7:0] b, input logic lb, input bit keep);
    int      p;
    int      ihl;
    int      udp0;
    int      flen;
    reason_t why;
    result_t r;
    p = int'(pos);
    if (p == int'(POS_ETYPE_HI)) etype[15:8] = b;
    if (p == int'(POS_ETYPE_LO)) etype[7:0] = b;
    if (p == int'(POS_VER_IHL)) ver_ihl = b;
    if (p == int'(POS_PROTOCOL)) proto = b;
    if (p >= int'(POS_SRC_FIRST) && p <= int'(POS_SRC_LAST)) src_addr = {src_addr[23:0], b};
    ihl  = int'(ver_ihl[3:0]) * 4;
    udp0 = int'(ETH_HDR) + ihl;
    if (p > int'(POS_VER_IHL)) begin
      if (p == udp0 + 2) dport[15:8] = b;
      if (p == udp0 + 3) dport[7:0] = b;
      if (p == udp0 + 4) ulen[15:8] = b;
      if (p == udp0 + 5) ulen[7:0] = b;
    end
    // Tentative payload: forward while every check decidable so far passes
    if (p > udp0 + 5 && etype == ETHERTYPE_IPV4 && ver_ihl[7:4] == IPV4_VERSION &&
        ihl >= int'(MIN_IHL_BYTES) && proto == PROTO_UDP && dport == cfg_port &&
        ulen >= UDP_HDR && p >= udp0 + int'(UDP_HDR) && p < udp0 + int'(ulen)) begin
      r = '0;
      r.result_kind  = KIND_PAYLOAD;
      r.payload_byte = b;
      if (keep) awaited_items.push_back(r);
    end
    if (lb) begin
      flen = p + 1;
      if (flen < int'(MIN_FRAME_LEN)) why = REASON_SHORT;
      else if (etype != ETHERTYPE_IPV4) why = REASON_ETHERTYPE;
      else if (ver_ihl[7:4] != IPV4_VERSION) why = REASON_VERSION;
      else if (ihl < int'(MIN_IHL_BYTES)) why = REASON_IHL;
      else if (flen < udp0 + int'(UDP_HDR)) why = REASON_SHORT;
      else if (proto != PROTO_UDP) why = REASON_PROTOCOL;
      else if (dport != cfg_port) why = REASON_PORT;
      else if (ulen < UDP_HDR || int'(ulen) > flen - udp0) why = REASON_UDP_LENGTH;
      else why = REASON_OK;
      r = '0;
      r.result_kind   = KIND_VERDICT;
      r.reject_reason = why;
      r.last          = 1'b1;
      if (why == REASON_OK) begin
        r.accepted       = 1'b1;
        r.source_ip      = src_addr;
        r.payload_length = ulen - UDP_HDR;
      end
      if (keep) awaited_items.push_back(r);
      pos = '0; etype = '0; ver_ihl = '0; proto = '0;
      src_addr = '0; dport = '0; ulen = '0;
    end else if (pos < POS_MAX) begin
      pos = pos + 17'd1;
    end
  endfunction

  // Offer one byte, idling at random first; hold it until the block takes it.
  task automatic push_byte(input logic [7:0] b, input logic lb, input bit typed,
                           input result_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.data_byte <= b;
    rx_if.last_byte <= lb;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    filter_one_byte(b, lb, !typed);
    if (typed) awaited_items.push_back(want);
  endtask

  // Drop valid and hold until every awaited item has come back.
  task automatic hold_until_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited_items.size() != 0) @(posedge clk);
  endtask

  task automatic write_port(input logic [15:0] value);
    hold_until_drained();
    // A trailing byte may still sit in the pipe without producing an item
    repeat (DRAIN_WAIT) @(posedge clk);
    udp_port_we    <= 1'b1;
    udp_port_wdata <= value;
    @(posedge clk);
    udp_port_we <= 1'b0;
    cfg_port = value;
  endtask

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one frame in frame_q: noise, a clean UDP datagram, or one with a single defect.
  task automatic build_frame(input bit clean, input int plen_force, input int pad_force);
    int          mut;
    int          ihl_words;
    int          plen;
    int          pad;
    int          cut;
    logic [15:0] ulen_field;
    logic [15:0] word;
    logic [3:0]  ver;
    frame_q.delete();
    if (!clean && $urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 70)) frame_q.push_back(rand8());
      return;
    end
    mut = clean ? 0 : $urandom_range(0, 15);
    ihl_words = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
    if (mut == 10) ihl_words = $urandom_range(0, 4);
    if (plen_force >= 0) plen = plen_force;
    else plen = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
    if (pad_force >= 0) pad = pad_force;
    else pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    ulen_field = 16'(8 + plen);
    if (mut == 13) ulen_field = 16'($urandom_range(0, 7));
    if (mut == 14) ulen_field = 16'(8 + plen + pad + $urandom_range(1, 20));
    // Ethernet header
    repeat (12) frame_q.push_back(rand8());
    word = ETHERTYPE_IPV4;
    if (mut == 8) begin
      word = 16'($urandom_range(0, 65535));
      if (word == ETHERTYPE_IPV4) word[0] = 1'b1;
    end
    frame_q.push_back(word[15:8]);
    frame_q.push_back(word[7:0]);
    // IPv4 header, options sized by IHL when it is above five words
    ver = IPV4_VERSION;
    if (mut == 9) begin
      ver = 4'($urandom_range(0, 14));
      if (ver >= IPV4_VERSION) ver = ver + 4'd1;
    end
    frame_q.push_back({ver, 4'(ihl_words)});
    repeat (8) frame_q.push_back(rand8());
    word[7:0] = PROTO_UDP;
    if (mut == 11) begin
      word[7:0] = rand8();
      if (word[7:0] == PROTO_UDP) word[7:0] = word[7:0] ^ 8'h80;
    end
    frame_q.push_back(word[7:0]);
    repeat (10) frame_q.push_back(rand8());
    if (ihl_words > 5) repeat ((ihl_words - 5) * 4) frame_q.push_back(rand8());
    // UDP header and payload
    repeat (2) frame_q.push_back(rand8());
    word = cfg_port;
    if (mut == 12) word = cfg_port ^ 16'($urandom_range(1, 65535));
    frame_q.push_back(word[15:8]);
    frame_q.push_back(word[7:0]);
    frame_q.push_back(ulen_field[15:8]);
    frame_q.push_back(ulen_field[7:0]);
    repeat (2) frame_q.push_back(rand8());
    repeat (plen) frame_q.push_back(rand8());
    repeat (pad) frame_q.push_back(rand8());
    if (mut == 15) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endtask

  task automatic send_frame(input int pause_at);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == pause_at) hold_until_drained();
      push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, NO_RESULT);
    end
  endtask

  task automatic run_frames(input int byte_goal, input int frame_goal, input bit with_stall,
                            input bit with_pause);
    int nb;
    int nf;
    int pause_at;
    nb = 0;
    nf = 0;
    while (nb < byte_goal || nf < frame_goal) begin
      pause_at = -1;
      if (with_stall && nf == 3) begin
        // Long payload while the receiver holds off: fill the result queue
        build_frame(1'b1, 40, 0);
        stall_request = 150;
      end else if (with_pause && nf == 5) begin
        build_frame(1'b1, 30, 0);
        pause_at = frame_q.size() - 10;
      end else begin
        build_frame(1'b0, -1, -1);
      end
      send_frame(pause_at);
      nb += frame_q.size();
      nf++;
    end
  endtask

  // Receiver: check each accepted item against the oldest expectation, then pick ready.
  always @(posedge clk) begin
    if (rst) begin
      tx_if.ready <= 1'b0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        seen_item.result_kind    = tx_if.result_kind;
        seen_item.payload_byte   = tx_if.payload_byte;
        seen_item.accepted       = tx_if.accepted;
        seen_item.reject_reason  = reason_t'(tx_if.reject_reason);
        seen_item.source_ip      = tx_if.source_ip;
        seen_item.payload_length = tx_if.payload_length;
        seen_item.last           = tx_if.last;
        if (awaited_items.size() == 0) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("unexpected item: kind=%0d byte=%h acc=%0d reason=%0d ip=%h len=%0d last=%0d",
                     seen_item.result_kind, seen_item.payload_byte, seen_item.accepted,
                     seen_item.reject_reason, seen_item.source_ip, seen_item.payload_length,
                     seen_item.last);
        end else begin
          want_item = awaited_items.pop_front();
          if (seen_item.result_kind !== want_item.result_kind ||
              seen_item.payload_byte !== want_item.payload_byte ||
              seen_item.accepted !== want_item.accepted ||
              seen_item.reject_reason !== want_item.reject_reason ||
              seen_item.source_ip !== want_item.source_ip ||
              seen_item.payload_length !== want_item.payload_length ||
              seen_item.last !== want_item.last) begin
            err_count++;
            if (err_count <= MAX_SHOWN) begin
              $display("mismatch exp: kind=%0d byte=%h acc=%0d reason=%0d ip=%h len=%0d last=%0d",
                       want_item.result_kind, want_item.payload_byte, want_item.accepted,
                       want_item.reject_reason, want_item.source_ip, want_item.payload_length,
                       want_item.last);
              $display("         got: kind=%0d byte=%h acc=%0d reason=%0d ip=%h len=%0d last=%0d",
                       seen_item.result_kind, seen_item.payload_byte, seen_item.accepted,
                       seen_item.reject_reason, seen_item.source_ip, seen_item.payload_length,
                       seen_item.last);
            end
          end
        end
      end
      if (stall_request > 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        tx_if.ready <= 1'b0;
        hold_left--;
      end else begin
        tx_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    rx_if.valid     = 1'b0;
    rx_if.data_byte = 8'h00;
    rx_if.last_byte = 1'b0;
    udp_port_we     = 1'b0;
    udp_port_wdata  = 16'h0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles more rarely than the receiver; port at its reset value
    src_idle_pct = 34;
    snk_idle_pct = 53;
    foreach (dir_rows[i])
      push_byte(dir_rows[i].data_byte, dir_rows[i].last_byte, dir_rows[i].typed,
                dir_rows[i].want);
    run_frames(380, 6, 1'b1, 1'b1);

    // Swap the idle rates; lowest port
    write_port(16'h0000);
    src_idle_pct = 53;
    snk_idle_pct = 34;
    run_frames(380, 6, 1'b0, 1'b1);

    // No idling at all; highest port
    write_port(16'hFFFF);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_frames(380, 6, 1'b1, 1'b0);

    // Random port; a short tail of mixed frames
    write_port(16'($urandom_range(0, 65535)));
    run_frames(150, 3, 1'b0, 1'b0);

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
